[hdl/beg_pkg.sv]
// ----------------------------------------------------------------
// beg_pkg: shared definitions for the bipolar envelope generator
// codes, widths, constants and controller/datapath handshake types
// ----------------------------------------------------------------
package beg_pkg;

  localparam int MODE_W   = 2;
  localparam int TICKS_W  = 8;
  localparam int LEVEL_W  = 8;
  localparam int STAGE_W  = 2;
  localparam int DUR_W    = 15;
  localparam int COUNT_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam int PROD_W   = DUR_W + LEVEL_W;

  // input item kinds
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  // envelope stages
  localparam logic [STAGE_W-1:0] STAGE_IDLE    = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_SUSTAIN = 2'd2;
  localparam logic [STAGE_W-1:0] STAGE_RELEASE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DR      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT  = 2'd3;

  localparam logic signed [LEVEL_W-1:0] ENV_PEAK = 8'sd127;
  localparam logic [DUR_W-1:0]          DR_RESET = 15'd400;
  localparam logic [COUNT_W-1:0]        COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic load;
    logic advance;
    logic eval;
    logic mul;
    logic div_init;
    logic div_step;
    logic fix;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic interp;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

[hdl/beg_if.sv]
// ----------------------------------------------------------------
// beg_if: stream channels of the bipolar envelope generator
// input request channel and result channel, valid/ready handshake
// ----------------------------------------------------------------
interface beg_in_if;
  logic                          valid;
  logic                          ready;
  logic [beg_pkg::MODE_W-1:0]    mode;
  logic [beg_pkg::TICKS_W-1:0]   ticks_passed;

  modport source(output valid, output mode, output ticks_passed, input ready);
  modport sink(input valid, input mode, input ticks_passed, output ready);
endinterface

interface beg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [beg_pkg::LEVEL_W-1:0]  level_out;
  logic [beg_pkg::STAGE_W-1:0]         stage;

  modport source(output valid, output level_out, output stage, input ready);
  modport sink(input valid, input level_out, input stage, output ready);
endinterface

[hdl/beg_ctrl.sv]
// ----------------------------------------------------------------
// beg_ctrl: sequencing controller
// walks one request: advance, eval, mul/div/fix if needed, emit
// ----------------------------------------------------------------
module beg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  beg_pkg::status_t status,
  output beg_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADV   = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DINIT = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_FIX   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = status.interp ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/beg_datapath.sv]
// ----------------------------------------------------------------
// beg_datapath: envelope state, interpolation and result register
// shared 15x8 multiplier and 8-step restoring divider
// ----------------------------------------------------------------
module beg_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [beg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [beg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  beg_pkg::cmd_t                      cmd,
  output beg_pkg::status_t                   status,
  input  logic [beg_pkg::MODE_W-1:0]         mode_in,
  input  logic [beg_pkg::TICKS_W-1:0]        ticks_in,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [beg_pkg::LEVEL_W-1:0] level_out,
  output logic [beg_pkg::STAGE_W-1:0]        stage_out
);

  // configuration
  logic [beg_pkg::DUR_W-1:0]          attack_ticks;
  logic [beg_pkg::DUR_W-1:0]          decay_release_ticks;
  logic signed [beg_pkg::LEVEL_W-1:0] sustain_level;
  logic                               invert;

  // request and envelope state
  logic [beg_pkg::MODE_W-1:0]         mode_q;
  logic [beg_pkg::TICKS_W-1:0]        ticks_q;
  logic [beg_pkg::STAGE_W-1:0]        stage_reg;
  logic [beg_pkg::COUNT_W-1:0]        tick_count;
  logic signed [beg_pkg::LEVEL_W-1:0] level_reg;
  logic signed [beg_pkg::LEVEL_W-1:0] release_start;

  // interpolation operands
  logic [beg_pkg::DUR_W-1:0]          off;
  logic [beg_pkg::DUR_W-1:0]          span;
  logic signed [beg_pkg::LEVEL_W-1:0] y0;
  logic                               diff_neg;
  logic [beg_pkg::LEVEL_W-1:0]        diff_mag;
  logic [beg_pkg::PROD_W-1:0]         prod;
  logic [beg_pkg::DUR_W-1:0]          rem;
  logic [beg_pkg::LEVEL_W-1:0]        quo;
  logic [2:0]                         div_cnt;

  // combinational helpers
  logic [beg_pkg::COUNT_W:0]          tick_sum;
  logic [beg_pkg::COUNT_W-1:0]        tick_sat;
  logic [beg_pkg::COUNT_W-1:0]        ad_sum;
  logic                               ad_end;
  logic                               in_decay;
  logic                               rel_end;
  logic signed [beg_pkg::LEVEL_W:0]   diff9;
  logic [beg_pkg::LEVEL_W:0]          diff9_abs;
  logic [beg_pkg::COUNT_W-1:0]        decay_off;
  logic [beg_pkg::COUNT_W:0]          trial;
  logic signed [beg_pkg::LEVEL_W:0]   q_signed;
  logic signed [beg_pkg::LEVEL_W:0]   fix_sum;
  logic signed [beg_pkg::LEVEL_W-1:0] out_lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks        <= '0;
      decay_release_ticks <= beg_pkg::DR_RESET;
      sustain_level       <= '0;
      invert              <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        beg_pkg::CFG_ATTACK:  attack_ticks <= cfg_data;
        beg_pkg::CFG_DR:      decay_release_ticks <= cfg_data;
        beg_pkg::CFG_SUSTAIN: sustain_level <= cfg_data[beg_pkg::LEVEL_W-1:0];
        beg_pkg::CFG_INVERT:  invert <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode_in;
      ticks_q <= ticks_in;
    end
  end

  // saturating tick advance
  assign tick_sum = {1'b0, tick_count} + {{(beg_pkg::COUNT_W + 1 - beg_pkg::TICKS_W){1'b0}}, ticks_q};
  assign tick_sat = tick_sum[beg_pkg::COUNT_W] ? beg_pkg::COUNT_MAX
                                               : tick_sum[beg_pkg::COUNT_W-1:0];

  // segment decisions on the advanced count
  assign ad_sum    = {1'b0, attack_ticks} + {1'b0, decay_release_ticks};
  assign ad_end    = (tick_count >= ad_sum);
  assign in_decay  = (tick_count >= {1'b0, attack_ticks});
  assign rel_end   = (tick_count >= {1'b0, decay_release_ticks});
  assign decay_off = tick_count - {1'b0, attack_ticks};

  always_comb begin
    if (stage_reg == beg_pkg::STAGE_RELEASE) begin
      diff9 = 9'sd0 - {release_start[beg_pkg::LEVEL_W-1], release_start};
    end else if (in_decay) begin
      diff9 = {sustain_level[beg_pkg::LEVEL_W-1], sustain_level}
              - {beg_pkg::ENV_PEAK[beg_pkg::LEVEL_W-1], beg_pkg::ENV_PEAK};
    end else begin
      diff9 = {beg_pkg::ENV_PEAK[beg_pkg::LEVEL_W-1], beg_pkg::ENV_PEAK};
    end
  end
  assign diff9_abs = diff9[beg_pkg::LEVEL_W] ? (9'd0 - diff9) : diff9;

  assign status.interp = (mode_q == beg_pkg::MODE_TICK) &&
                         (((stage_reg == beg_pkg::STAGE_ATTACK) && !ad_end) ||
                          ((stage_reg == beg_pkg::STAGE_RELEASE) && !rel_end));
  assign status.div_last = (div_cnt == 3'd7);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg     <= beg_pkg::STAGE_IDLE;
      tick_count    <= '0;
      level_reg     <= '0;
      release_start <= '0;
    end else if (cmd.advance) begin
      case (mode_q)
        beg_pkg::MODE_TRIGGER: begin
          tick_count <= '0;
          stage_reg  <= beg_pkg::STAGE_ATTACK;
        end
        beg_pkg::MODE_RELEASE: begin
          tick_count    <= '0;
          release_start <= level_reg;
          stage_reg     <= beg_pkg::STAGE_RELEASE;
        end
        beg_pkg::MODE_TICK: begin
          case (stage_reg)
            beg_pkg::STAGE_IDLE:    level_reg <= '0;
            beg_pkg::STAGE_SUSTAIN: level_reg <= sustain_level;
            default:                tick_count <= tick_sat;
          endcase
        end
        default: ;
      endcase
    end else if (cmd.eval) begin
      if (mode_q == beg_pkg::MODE_TICK) begin
        if ((stage_reg == beg_pkg::STAGE_ATTACK) && ad_end) begin
          level_reg <= sustain_level;
          stage_reg <= beg_pkg::STAGE_SUSTAIN;
        end else if ((stage_reg == beg_pkg::STAGE_RELEASE) && rel_end) begin
          level_reg <= '0;
          stage_reg <= beg_pkg::STAGE_IDLE;
        end
      end
    end else if (cmd.fix) begin
      level_reg <= fix_sum[beg_pkg::LEVEL_W-1:0];
    end
  end

  // operand capture and multiply
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      diff_neg <= diff9[beg_pkg::LEVEL_W];
      diff_mag <= diff9_abs[beg_pkg::LEVEL_W-1:0];
      if (stage_reg == beg_pkg::STAGE_RELEASE) begin
        off  <= tick_count[beg_pkg::DUR_W-1:0];
        span <= decay_release_ticks;
        y0   <= release_start;
      end else if (in_decay) begin
        off  <= decay_off[beg_pkg::DUR_W-1:0];
        span <= decay_release_ticks;
        y0   <= beg_pkg::ENV_PEAK;
      end else begin
        off  <= tick_count[beg_pkg::DUR_W-1:0];
        span <= attack_ticks;
        y0   <= '0;
      end
    end
    if (cmd.mul) begin
      prod <= {{beg_pkg::LEVEL_W{1'b0}}, off} * {{beg_pkg::DUR_W{1'b0}}, diff_mag};
    end
  end

  // quotient stays below 256 since off < span, so eight steps suffice
  assign trial = {1'b0, rem, quo[beg_pkg::LEVEL_W-1]} - {2'b0, span};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= prod[beg_pkg::PROD_W-1:beg_pkg::LEVEL_W];
      quo     <= prod[beg_pkg::LEVEL_W-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 3'd1;
      if (!trial[beg_pkg::COUNT_W]) begin
        rem <= trial[beg_pkg::DUR_W-1:0];
        quo <= {quo[beg_pkg::LEVEL_W-2:0], 1'b1};
      end else begin
        rem <= {rem[beg_pkg::DUR_W-2:0], quo[beg_pkg::LEVEL_W-1]};
        quo <= {quo[beg_pkg::LEVEL_W-2:0], 1'b0};
      end
    end
  end

  // truncation toward zero: divide magnitudes, then apply the sign
  assign q_signed = diff_neg ? (9'sd0 - $signed({1'b0, quo})) : $signed({1'b0, quo});
  assign fix_sum  = {y0[beg_pkg::LEVEL_W-1], y0} + q_signed;

  assign out_lvl = invert ? (8'sd0 - level_reg) : level_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      level_out <= out_lvl;
      stage_out <= stage_reg;
    end
  end

endmodule

[hdl/bipolar_envelope_generator.sv]
// ----------------------------------------------------------------
// bipolar_envelope_generator: linear attack/decay/sustain/release
// envelope with shared decay/release time and signed sustain level
// ----------------------------------------------------------------
// Each request on in_chan is a trigger, a release or a tick advance
// carrying elapsed ticks; each request yields exactly one result on
// out_chan with the level after the step (negated when invert is set)
// and the stage. Requests are handled one at a time. After a trigger,
// a release, the unused request code, a tick in idle or sustain, or a
// tick that ends attack/decay or release, the controller goes from
// advance and evaluate straight to the result; a tick that stays
// inside attack, decay or release also takes the interpolation path:
// one 15x8 multiply followed by an 8-step restoring divider that
// produces one quotient bit per cycle.
// The result register holds a finished result while the next request
// is taken; the block only stalls at the end of a request when the
// previous result is still unclaimed. Configuration registers (attack
// ticks, decay/release ticks, sustain level, invert) are written through
// cfg_write/cfg_index/cfg_data and must only change while idle.
// ----------------------------------------------------------------
module bipolar_envelope_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [beg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [beg_pkg::CFG_DATA_W-1:0]     cfg_data,
  beg_in_if.sink                             in_chan,
  beg_out_if.source                          out_chan
);

  // command and status between controller and datapath
  beg_pkg::cmd_t    cmd;
  beg_pkg::status_t status;

  // controller: one request at a time, ready only when idle
  beg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: config, envelope state, mul/div and result register
  beg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .mode_in   (in_chan.mode),
    .ticks_in  (in_chan.ticks_passed),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .level_out (out_chan.level_out),
    .stage_out (out_chan.stage)
  );

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------
// tb: self-checking bench for the bipolar envelope generator
// drives trigger, release and tick requests with random idling on
// both channels, predicts every level/stage result and compares it
// ----------------------------------------------------------------
module tb;
  import beg_pkg::*;

  // the one request code the package leaves unnamed
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic [STAGE_W-1:0]        stage;
  } env_result_t;

  // ------------------------------------------------------------
  // envelope predictor plus queue of the results still owed
  // ------------------------------------------------------------
  class envelope_checker;
    // register copies
    logic [DUR_W-1:0]          attack_c;
    logic [DUR_W-1:0]          decay_c;
    logic signed [LEVEL_W-1:0] sustain_c;
    logic                      invert_c;
    // envelope state
    logic [STAGE_W-1:0]        stage_q;
    logic [COUNT_W-1:0]        tick_cnt;
    logic signed [LEVEL_W-1:0] level_q;
    logic signed [LEVEL_W-1:0] release_lvl;

    env_result_t owed_q[$];
    int mismatches;
    int results_seen;

    function new();
      attack_c     = '0;
      decay_c      = DR_RESET;
      sustain_c    = '0;
      invert_c     = 1'b0;
      stage_q      = STAGE_IDLE;
      tick_cnt     = '0;
      level_q      = '0;
      release_lvl  = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ATTACK:  attack_c  = data[DUR_W-1:0];
        CFG_DR:      decay_c   = data[DUR_W-1:0];
        CFG_SUSTAIN: sustain_c = data[LEVEL_W-1:0];
        CFG_INVERT:  invert_c  = data[0];
        default: ;
      endcase
    endfunction

    // straight-line interpolation, division truncates toward zero
    function int ramp(input int off, input int span, input int y0, input int y1);
      if (span == 0) return y1;
      return (off * (y1 - y0)) / span + y0;
    endfunction

    function void step_count(input logic [TICKS_W-1:0] n);
      int t;
      t = int'(tick_cnt) + int'(n);
      tick_cnt = (t > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(t);
    endfunction

    function void note_request(input logic [MODE_W-1:0] mode,
                               input logic [TICKS_W-1:0] ticks);
      int atk;
      int dr;
      int cnt;
      int lvl;
      env_result_t r;
      atk = int'(attack_c);
      dr  = int'(decay_c);
      case (mode)
        MODE_TRIGGER: begin
          tick_cnt = '0;
          stage_q  = STAGE_ATTACK;
        end
        MODE_RELEASE: begin
          tick_cnt    = '0;
          release_lvl = level_q;
          stage_q     = STAGE_RELEASE;
        end
        MODE_TICK: begin
          case (stage_q)
            STAGE_IDLE:    level_q = '0;
            STAGE_SUSTAIN: level_q = sustain_c;
            STAGE_ATTACK: begin
              step_count(ticks);
              cnt = int'(tick_cnt);
              if (cnt >= atk + dr) begin
                level_q = sustain_c;
                stage_q = STAGE_SUSTAIN;
              end else if (cnt >= atk) begin
                level_q = LEVEL_W'(ramp(cnt - atk, dr, int'(ENV_PEAK), int'(sustain_c)));
              end else begin
                level_q = LEVEL_W'(ramp(cnt, atk, 0, int'(ENV_PEAK)));
              end
            end
            default: begin
              step_count(ticks);
              cnt = int'(tick_cnt);
              if (cnt >= dr) begin
                level_q = '0;
                stage_q = STAGE_IDLE;
              end else begin
                level_q = LEVEL_W'(ramp(cnt, dr, int'(release_lvl), 0));
              end
            end
          endcase
        end
        default: ;
      endcase
      lvl = invert_c ? -int'(level_q) : int'(level_q);
      r.level = LEVEL_W'(lvl);
      r.stage = stage_q;
      owed_q.push_back(r);
    endfunction

    function void check_result(input logic signed [LEVEL_W-1:0] level,
                               input logic [STAGE_W-1:0] stage);
      env_result_t r;
      results_seen++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: level %0d stage %0d", level, stage);
        return;
      end
      r = owed_q.pop_front();
      if (r.level !== level || r.stage !== stage) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at result %0d: level exp %0d got %0d, stage exp %0d got %0d",
                   results_seen, r.level, level, r.stage, stage);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  // ------------------------------------------------------------
  // clock, reset, channels, block
  // ------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit steady = 1'b0;   // high: neither side idles

  envelope_checker sb = new();

  beg_in_if  req_if();
  beg_out_if res_if();

  always #5 clk = ~clk;

  bipolar_envelope_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (req_if),
    .out_chan  (res_if)
  );

  // idle lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // durations: small ones so stages get crossed, plus extremes
  function automatic logic [DUR_W-1:0] pick_dur();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return DUR_W'($urandom_range(0, 32767));
    return DUR_W'($urandom_range(1, 600));
  endfunction

  function automatic logic [TICKS_W-1:0] pick_ticks();
    if ($urandom_range(0, 3) == 0) return TICKS_W'($urandom_range(0, 15));
    return TICKS_W'($urandom_range(0, 255));
  endfunction

  // ------------------------------------------------------------
  // request side
  // ------------------------------------------------------------

  // offer one request, optionally after an idle gap, and wait for the handshake;
  // valid stays high afterwards so back-to-back requests need no second assignment
  task automatic offer(input logic [MODE_W-1:0] mode, input logic [TICKS_W-1:0] ticks);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.mode         <= mode;
    req_if.ticks_passed <= ticks;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(mode, ticks);
  endtask

  // stop offering and let every owed result drain before touching registers
  task automatic settle();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic load_config(input logic [DUR_W-1:0] atk, input logic [DUR_W-1:0] dr,
                             input logic signed [LEVEL_W-1:0] sus, input logic inv);
    put_reg(CFG_ATTACK, atk);
    put_reg(CFG_DR, dr);
    put_reg(CFG_SUSTAIN, {{(CFG_DATA_W-LEVEL_W){sus[LEVEL_W-1]}}, sus});
    put_reg(CFG_INVERT, {{(CFG_DATA_W-1){1'b0}}, inv});
    cfg_write <= 1'b0;
  endtask

  // mostly whole note cycles (trigger, ticks, release, ticks), some random noise
  task automatic run_random(input int quota);
    int sent;
    int k;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) < 7) begin
        offer(MODE_TRIGGER, TICKS_W'($urandom_range(0, 255)));
        sent++;
        k = $urandom_range(0, 20);
        repeat (k) begin
          offer(MODE_TICK, pick_ticks());
          sent++;
        end
        if ($urandom_range(0, 9) != 0) begin
          offer(MODE_RELEASE, TICKS_W'($urandom_range(0, 255)));
          sent++;
        end
        k = $urandom_range(0, 12);
        repeat (k) begin
          offer(MODE_TICK, pick_ticks());
          sent++;
        end
      end else begin
        offer(MODE_W'($urandom_range(0, 3)), TICKS_W'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    req_if.valid        = 1'b0;
    req_if.mode         = MODE_TICK;
    req_if.ticks_passed = '0;
    cfg_write           = 1'b0;
    cfg_index           = CFG_ATTACK;
    cfg_data            = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: attack 0, shared decay/release 400, sustain 0
    offer(MODE_TICK, 8'd255);          // tick while idle
    offer(MODE_UNUSED, 8'hAA);         // unused code changes nothing
    offer(MODE_TRIGGER, 8'h55);
    offer(MODE_TICK, 8'd0);            // zero attack: straight to peak
    offer(MODE_TICK, 8'd200);          // halfway down the decay
    offer(MODE_TICK, 8'd255);          // past the end of decay, into sustain
    offer(MODE_TICK, 8'd0);
    offer(MODE_RELEASE, 8'd0);
    offer(MODE_TICK, 8'd100);
    offer(MODE_TICK, 8'd255);          // still inside the release

    // longest attack, zero decay/release
    settle();
    load_config('1, '0, 8'sd127, 1'b0);
    offer(MODE_TRIGGER, 8'd0);
    offer(MODE_TICK, 8'd255);
    offer(MODE_TICK, 8'd255);
    offer(MODE_RELEASE, 8'd0);
    offer(MODE_TICK, 8'd0);            // zero release length ends at once

    // sustain of -128 with invert: negation wraps
    settle();
    load_config('0, '0, -8'sd128, 1'b1);
    offer(MODE_TRIGGER, 8'd0);
    offer(MODE_TICK, 8'd0);
    offer(MODE_TICK, 8'd7);
    offer(MODE_RELEASE, 8'd0);
    offer(MODE_TICK, 8'd3);

    // short stages with negative slopes, truncation toward zero
    settle();
    load_config(15'd3, 15'd5, -8'sd127, 1'b1);
    offer(MODE_TRIGGER, 8'd0);
    offer(MODE_TICK, 8'd1);
    offer(MODE_TICK, 8'd3);
    offer(MODE_RELEASE, 8'd0);
    offer(MODE_TICK, 8'd2);

    // random settings, every fourth phase with no idling on either side
    for (int p = 0; p < 8; p++) begin
      settle();
      steady = (p % 4 == 3);
      load_config(pick_dur(), pick_dur(), LEVEL_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      run_random(105);
    end

    // both durations at maximum: tick counter hits its ceiling
    settle();
    steady = 1'b0;
    load_config('1, '1, LEVEL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    offer(MODE_TRIGGER, 8'd0);
    offer(MODE_TICK, 8'd1);
    repeat (256) offer(MODE_TICK, 8'd255);
    offer(MODE_TICK, 8'd255);          // saturates the counter, lands in sustain
    offer(MODE_TICK, 8'd0);
    offer(MODE_RELEASE, 8'd0);
    offer(MODE_TICK, 8'd255);
    offer(MODE_TICK, 8'd255);

    // drain, then allow the block's latency before judging
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0d results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // ------------------------------------------------------------
  // result side: random hold-offs, plus a few long ones so the
  // block backs up and stalls the request channel
  // ------------------------------------------------------------
  initial begin
    int hold;
    hold = 0;
    res_if.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        sb.check_result(res_if.level_out, res_if.stage);
        hold = steady ? 0 : pick_gap();
        if (sb.results_seen % 450 == 150)
          hold = 250;                  // long back-pressure stretch
      end else if (hold > 0) begin
        hold--;
      end
      res_if.ready <= (hold == 0);
    end
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

[filelist.f]
hdl/beg_pkg.sv
hdl/beg_if.sv
hdl/beg_ctrl.sv
hdl/beg_datapath.sv
hdl/bipolar_envelope_generator.sv
verif/tb.sv
